/* hw/rtl/ermc_pkg.sv */
// Shared types and constants for the echo median range converter.
// Holds the payload structs, the cell link struct and the divisor tables.
// No dependencies.
package ermc_pkg;

    localparam int MaxSamples = 16;
    localparam int CountW     = $clog2(MaxSamples + 1);

    localparam int CfgW  = 5;
    localparam int EchoW = 16;
    localparam int TempW = 12;
    localparam int DistW = 11;
    localparam int DivW  = 6;
    localparam int NumW  = EchoW + 1;

    localparam logic [CfgW-1:0] CfgReset = CfgW'(5);

    // divisor per temperature band; band thresholds in tenths of a degree
    localparam int DivCold = 59;
    localparam int DivMild = 58;
    localparam int DivWarm = 57;
    localparam logic signed [TempW-1:0] TempMild = TempW'(174);
    localparam logic signed [TempW-1:0] TempWarm = TempW'(273);

    // reciprocals scaled by 2^RecipShift, rounded down
    localparam int RecipShift = 22;
    localparam int RecipW     = 17;
    localparam logic [RecipW-1:0] RecipCold = RecipW'((1 << RecipShift) / DivCold);
    localparam logic [RecipW-1:0] RecipMild = RecipW'((1 << RecipShift) / DivMild);
    localparam logic [RecipW-1:0] RecipWarm = RecipW'((1 << RecipShift) / DivWarm);

    typedef struct packed {
        logic        [EchoW-1:0] echo_time;
        logic signed [TempW-1:0] temperature_tenths;
    } t_in;

    typedef struct packed {
        logic [DistW-1:0]  distance_cm;
        logic              no_echo;
        logic [EchoW-1:0]  median_echo_time;
        logic [CountW-1:0] valid_samples;
    } t_out;

    // handed from one sort cell to the next
    typedef struct packed {
        logic             keep;
        logic [EchoW-1:0] echo;
    } t_link;

    function automatic logic [RecipW-1:0] recip(input logic [DivW-1:0] d);
        logic [RecipW-1:0] r;
        case (d)
            DivW'(DivMild): r = RecipMild;
            DivW'(DivWarm): r = RecipWarm;
            default:        r = RecipCold;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/ermc_cell.sv */
// One cell of the insertion sort chain: holds one echo time.
// Depends on ermc_pkg for the link struct and widths.
module ermc_cell (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic [ermc_pkg::EchoW-1:0]   i_echo,
    input  logic                         i_occupied,
    input  ermc_pkg::t_link              i_up,
    output ermc_pkg::t_link              o_down
);

    logic [ermc_pkg::EchoW-1:0] r_echo;
    logic                       w_keep;

    // hold when this entry ranks at or above the new time
    assign w_keep = i_occupied && (r_echo >= i_echo);

    always_ff @(posedge i_clk) begin
        if (i_load && !w_keep) begin
            r_echo <= i_up.keep ? i_echo : i_up.echo;
        end
    end

    assign o_down.keep = w_keep;
    assign o_down.echo = r_echo;

endmodule

/* hw/rtl/ermc_conv.sv */
// Rounded division of the median time by the temperature divisor.
// Reciprocal multiply, then one correction step. Depends on ermc_pkg.
module ermc_conv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ermc_pkg::NumW-1:0]   i_num,
    input  logic [ermc_pkg::DivW-1:0]   i_div,
    output logic                        o_done,
    output logic [ermc_pkg::DistW-1:0]  o_quot
);

    localparam int ProdW = ermc_pkg::NumW + ermc_pkg::RecipW;

    logic [ermc_pkg::NumW-1:0]  r_x;
    logic [ermc_pkg::DivW-1:0]  r_div;
    logic [ermc_pkg::DistW-1:0] r_q0;
    logic [ermc_pkg::DistW-1:0] r_q;
    logic                       r_v1, r_v2, r_v3;

    logic [ProdW-1:0]           w_prod;
    logic [ermc_pkg::NumW-1:0]  w_qd;
    logic [ermc_pkg::NumW-1:0]  w_rem;

    assign w_prod = ProdW'(r_x) * ProdW'(ermc_pkg::recip(r_div));
    assign w_qd   = ermc_pkg::NumW'(r_q0) * ermc_pkg::NumW'(r_div);
    assign w_rem  = r_x - w_qd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_num;
            r_div <= i_div;
        end
        if (r_v1) begin
            r_q0 <= ermc_pkg::DistW'(w_prod >> ermc_pkg::RecipShift);
        end
        // estimate is low by at most one
        if (r_v2) begin
            r_q <= r_q0 + ermc_pkg::DistW'(w_rem >= ermc_pkg::NumW'(r_div));
        end
    end

    assign o_done = r_v3;
    assign o_quot = r_q;

endmodule

/* hw/rtl/echo_median_range_converter.sv */
// Echo median range converter: a transfer with a nonzero echo time inserts it.
// The transfer that ends a batch holds off input through median select,
// conversion and result load, longer while the output register is full.
// Reset (i_rst_n low, synchronous): counters, state and valid clear, batch length 5;
// stored echo times are not cleared. Depends on ermc_pkg, ermc_cell, ermc_conv.
module echo_median_range_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ermc_pkg::CfgW-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ermc_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ermc_pkg::t_out                o_out_data
);

    // sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;  // take echo times
    localparam logic [1:0] S_SEL  = 2'd1;  // pick the median, start conversion
    localparam logic [1:0] S_CONV = 2'd2;  // wait for the divider
    localparam logic [1:0] S_PUSH = 2'd3;  // load the output register

    localparam int CountW = ermc_pkg::CountW;
    localparam int EchoW  = ermc_pkg::EchoW;

    logic [1:0]                 r_state, n_state;
    logic [ermc_pkg::CfgW-1:0]  r_cfg;
    logic [CountW-1:0]          r_valid_cnt, n_valid_cnt;
    logic [CountW-1:0]          r_att_cnt, n_att_cnt;
    logic [CountW-1:0]          r_k;
    logic signed [ermc_pkg::TempW-1:0] r_temp;
    logic [EchoW-1:0]           r_med;
    logic                       r_out_valid;
    ermc_pkg::t_out             r_out;

    logic                       w_accept;
    logic                       w_insert;
    logic [CountW-1:0]          w_len;
    logic [CountW-1:0]          w_att_inc;
    logic                       w_batch_end;
    logic [EchoW-1:0]           w_med;
    logic [ermc_pkg::DivW-1:0]  w_div;
    logic [ermc_pkg::NumW-1:0]  w_num;
    logic                       w_start;
    logic                       w_done;
    logic [ermc_pkg::DistW-1:0] w_quot;
    logic                       w_out_free;

    ermc_pkg::t_link            w_link [ermc_pkg::MaxSamples+1];

    // ---------------------------------------------------------------
    // Batch bookkeeping
    // ---------------------------------------------------------------
    assign w_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // clamp the programmed length into 1..MaxSamples
    always_comb begin
        if (r_cfg == '0) begin
            w_len = CountW'(1);
        end else if (int'(r_cfg) > ermc_pkg::MaxSamples) begin
            w_len = CountW'(ermc_pkg::MaxSamples);
        end else begin
            w_len = CountW'(r_cfg);
        end
    end

    // drop a missing echo; the store never overflows within a batch
    assign w_insert    = w_accept && (i_in_data.echo_time != '0)
                         && (r_valid_cnt < CountW'(ermc_pkg::MaxSamples));
    assign w_att_inc   = r_att_cnt + CountW'(1);
    assign w_batch_end = (w_att_inc >= w_len);

    // ---------------------------------------------------------------
    // Insertion chain: cell 0 holds the largest time. Each cell keeps
    // its entry, takes the new time, or takes its upper neighbor's entry.
    // ---------------------------------------------------------------
    assign w_link[0].keep = 1'b1;
    assign w_link[0].echo = '0;

    for (genvar i = 0; i < ermc_pkg::MaxSamples; i++) begin : g_cell
        ermc_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (w_insert),
            .i_echo     (i_in_data.echo_time),
            .i_occupied (CountW'(i) < r_valid_cnt),
            .i_up       (w_link[i]),
            .o_down     (w_link[i+1])
        );
    end

    // ---------------------------------------------------------------
    // Median select and divisor choice from the last item's temperature
    // ---------------------------------------------------------------
    always_comb begin
        w_med = w_link[CountW'(r_k >> 1) + CountW'(1)].echo;
        if (r_k == '0) begin
            w_med = '0;
        end
    end

    always_comb begin
        if (r_temp >= ermc_pkg::TempWarm) begin
            w_div = ermc_pkg::DivW'(ermc_pkg::DivWarm);
        end else if (r_temp >= ermc_pkg::TempMild) begin
            w_div = ermc_pkg::DivW'(ermc_pkg::DivMild);
        end else begin
            w_div = ermc_pkg::DivW'(ermc_pkg::DivCold);
        end
    end

    // add half the divisor to round to nearest
    assign w_num   = ermc_pkg::NumW'(w_med) + ermc_pkg::NumW'(w_div >> 1);
    assign w_start = (r_state == S_SEL);

    ermc_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_div   (w_div),
        .o_done  (w_done),
        .o_quot  (w_quot)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_valid_cnt = r_valid_cnt;
        n_att_cnt   = r_att_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_batch_end) begin
                        n_valid_cnt = '0;
                        n_att_cnt   = '0;
                        n_state     = S_SEL;
                    end else begin
                        n_valid_cnt = r_valid_cnt + CountW'(w_insert);
                        n_att_cnt   = w_att_inc;
                    end
                end
            end
            S_SEL: begin
                n_state = S_CONV;
            end
            S_CONV: begin
                if (w_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= ermc_pkg::CfgReset;
            r_valid_cnt <= '0;
            r_att_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid_cnt <= n_valid_cnt;
            r_att_cnt   <= n_att_cnt;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            // drop valid on transfer, raise it when a result is loaded
            if ((r_state == S_PUSH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_temp <= i_in_data.temperature_tenths;
            if (w_batch_end) begin
                r_k <= r_valid_cnt + CountW'(w_insert);
            end
        end
        if (r_state == S_SEL) begin
            r_med <= w_med;
        end
        if ((r_state == S_PUSH) && w_out_free) begin
            r_out.distance_cm      <= (r_k == '0) ? '0 : w_quot;
            r_out.no_echo          <= (r_k == '0);
            r_out.median_echo_time <= r_med;
            r_out.valid_samples    <= r_k;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
